/* sv/decision_tree_classifier_defines.svh */
// Assertion macros shared by the decision tree classifier RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef DECISION_TREE_CLASSIFIER_DEFINES_SVH
`define DECISION_TREE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define DTC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define DTC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dtc_pkg.sv */
// Shared types and constants for the decision tree classifier.
// No dependencies; used by decision_tree_classifier.
package dtc_pkg;

  // Fixed field widths
  localparam int KIND_W     = 2;
  localparam int NODE_IDX_W = 8;
  localparam int FEAT_IDX_W = 5;
  localparam int VALUE_W    = 32;
  localparam int CLASS_W    = 4;

  // Default sizes
  localparam int NODE_COUNT_DEF    = 256;
  localparam int FEATURE_COUNT_DEF = 32;
  localparam int CLASS_COUNT_DEF   = 16;
  localparam int MAX_DEPTH_DEF     = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_NODE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FEATURE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLASSIFY = 2'd2;

  // Result status codes
  localparam logic STATUS_LEAF  = 1'b0;
  localparam logic STATUS_DEPTH = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [NODE_IDX_W-1:0]    node_index;
    logic                     node_is_leaf;
    logic [FEAT_IDX_W-1:0]    feature_index;
    logic signed [VALUE_W-1:0] split_threshold;
    logic [NODE_IDX_W-1:0]    left_child;
    logic [NODE_IDX_W-1:0]    right_child;
    logic [CLASS_W-1:0]       leaf_class;
    logic signed [VALUE_W-1:0] feature_value;
  } in_item_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic               status;
  } out_item_t;

  // One stored tree node, 58 bits
  typedef struct packed {
    logic                      leaf;
    logic [FEAT_IDX_W-1:0]     feat;
    logic signed [VALUE_W-1:0] thr;
    logic [NODE_IDX_W-1:0]     lo;
    logic [NODE_IDX_W-1:0]     hi;
    logic [CLASS_W-1:0]        cls;
  } node_t;

endpackage

/* sv/dtc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; instanced for the node table and the feature store.
module dtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port: hold data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/decision_tree_classifier.sv */
// Decision tree classifier top level: node table, feature store and walk sequencer.
// Depends on dtc_pkg, dtc_ram and decision_tree_classifier_defines.svh.
//
// A node write or feature write leaves in_stall low and gives no result. A classify
// walks the stored tree from node 0 and returns one transfer with the leaf's class,
// or status 1 when the depth limit is hit or a child lies outside the node table.
// The moves of a classify run one after another, each needing one node table read
// and then one feature store read feeding the single signed comparator, since both
// tables have one read port; the result is held while out_stall is high. in_stall is
// high from a classify until its result is transferred. Table contents are undefined
// after reset until written.
`include "decision_tree_classifier_defines.svh"

module decision_tree_classifier #(
  parameter int NODE_COUNT    = dtc_pkg::NODE_COUNT_DEF,
  parameter int FEATURE_COUNT = dtc_pkg::FEATURE_COUNT_DEF,
  parameter int CLASS_COUNT   = dtc_pkg::CLASS_COUNT_DEF,
  parameter int MAX_DEPTH     = dtc_pkg::MAX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtc_pkg::out_item_t out_data
);

  import dtc_pkg::*;

  // Only indexes reachable through the 8-bit and 5-bit fields get storage
  localparam int NODE_DEPTH = (NODE_COUNT < (1 << NODE_IDX_W)) ? NODE_COUNT
                                                               : (1 << NODE_IDX_W);
  localparam int FEAT_DEPTH = (FEATURE_COUNT < (1 << FEAT_IDX_W)) ? FEATURE_COUNT
                                                                  : (1 << FEAT_IDX_W);
  localparam int NODE_AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int FEAT_AW = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
  localparam int MOVE_W  = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_NODE = 4'b0010,
    S_FEAT = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NODE_IDX_W-1:0]  cur_r, cur_nxt;
  logic [MOVE_W-1:0]      moves_r, moves_nxt;
  logic [CLASS_W-1:0]     cls_r, cls_nxt;
  logic                   status_r, status_nxt;
  logic                   feat_ok_r, feat_ok_nxt;

  logic                   in_xfer;
  logic                   node_wr_en;
  node_t                  node_wr_data;
  logic                   node_rd_en;
  logic [NODE_AW-1:0]     node_rd_addr;
  logic [$bits(node_t)-1:0] node_rd_bits;
  node_t                  node_q;
  logic                   feat_wr_en;
  logic                   feat_rd_en;
  logic [FEAT_AW-1:0]     feat_rd_addr;
  logic [VALUE_W-1:0]     feat_rd_data;
  logic signed [VALUE_W-1:0] feat_val;
  logic                   go_left;
  logic [NODE_IDX_W-1:0]  child;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Table writes
  assign node_wr_en = in_xfer && (in_data.kind == KIND_NODE)
                      && (32'(in_data.node_index) < NODE_COUNT);
  assign feat_wr_en = in_xfer && (in_data.kind == KIND_FEATURE)
                      && (32'(in_data.feature_index) < FEATURE_COUNT);

  // Pack node, clamping the class into range
  always_comb begin
    node_wr_data.leaf = in_data.node_is_leaf;
    node_wr_data.feat = in_data.feature_index;
    node_wr_data.thr  = in_data.split_threshold;
    node_wr_data.lo   = in_data.left_child;
    node_wr_data.hi   = in_data.right_child;
    node_wr_data.cls  = (32'(in_data.leaf_class) >= CLASS_COUNT)
                        ? CLASS_W'(CLASS_COUNT - 1) : in_data.leaf_class;
  end

  dtc_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_wr_en),
    .wr_addr (in_data.node_index[NODE_AW-1:0]),
    .wr_data (node_wr_data),
    .rd_en   (node_rd_en),
    .rd_addr (node_rd_addr),
    .rd_data (node_rd_bits)
  );

  assign node_q = node_t'(node_rd_bits);

  dtc_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (FEAT_DEPTH)
  ) u_feat_ram (
    .clk     (clk),
    .wr_en   (feat_wr_en),
    .wr_addr (in_data.feature_index[FEAT_AW-1:0]),
    .wr_data (in_data.feature_value),
    .rd_en   (feat_rd_en),
    .rd_addr (feat_rd_addr),
    .rd_data (feat_rd_data)
  );

  // Shared comparator: feature against threshold, missing slots read zero
  assign feat_val = feat_ok_r ? signed'(feat_rd_data) : '0;
  assign go_left  = (feat_val < node_q.thr);
  assign child    = go_left ? node_q.lo : node_q.hi;

  // Walk sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    moves_nxt    = moves_r;
    cls_nxt      = cls_r;
    status_nxt   = status_r;
    feat_ok_nxt  = feat_ok_r;
    node_rd_en   = 1'b0;
    node_rd_addr = cur_r[NODE_AW-1:0];
    feat_rd_en   = 1'b0;
    feat_rd_addr = node_q.feat[FEAT_AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_xfer && (in_data.kind == KIND_CLASSIFY)) begin
          cur_nxt      = '0;
          moves_nxt    = '0;
          node_rd_en   = 1'b1;
          node_rd_addr = '0;
          state_nxt    = S_NODE;
        end
      end
      S_NODE: begin
        if (node_q.leaf) begin
          cls_nxt    = node_q.cls;
          status_nxt = STATUS_LEAF;
          state_nxt  = S_OUT;
        end else if (moves_r >= MOVE_W'(MAX_DEPTH)) begin
          cls_nxt    = '0;
          status_nxt = STATUS_DEPTH;
          state_nxt  = S_OUT;
        end else begin
          feat_rd_en  = 1'b1;
          feat_ok_nxt = (32'(node_q.feat) < FEATURE_COUNT);
          state_nxt   = S_FEAT;
        end
      end
      S_FEAT: begin
        moves_nxt = moves_r + 1'b1;
        cur_nxt   = child;
        if (32'(child) >= NODE_COUNT) begin
          cls_nxt    = '0;
          status_nxt = STATUS_DEPTH;
          state_nxt  = S_OUT;
        end else begin
          node_rd_en   = 1'b1;
          node_rd_addr = child[NODE_AW-1:0];
          state_nxt    = S_NODE;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      moves_r <= '0;
    end else begin
      state_r <= state_nxt;
      moves_r <= moves_nxt;
    end
  end

  // Hold walk payload
  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cls_r     <= cls_nxt;
    status_r  <= status_nxt;
    feat_ok_r <= feat_ok_nxt;
  end

  assign out_valid            = (state_r == S_OUT);
  assign out_data.class_index = cls_r;
  assign out_data.status      = status_r;

  `DTC_ASSERT_IMP(a_busy_while_result, out_valid, in_stall, "result pending but input open")
  `DTC_ASSERT_IMP(a_moves_bounded, 1'b1, moves_r <= MOVE_W'(MAX_DEPTH), "move count past limit")
  `DTC_ASSERT_IMP(a_error_class_zero, out_valid && (out_data.status == STATUS_DEPTH),
                  out_data.class_index == '0, "error result with nonzero class")
  `DTC_ASSERT_NXT(a_write_no_result, in_xfer && (in_data.kind != KIND_CLASSIFY),
                  !out_valid && !in_stall, "write or unknown item produced a result")

endmodule
